// ===== src/tftwg_pkg.sv =====
`timescale 1ns / 1ps

package tftwg_pkg;

   localparam int FONT_ENTRIES_DEF = 2048;
   localparam int GLYPH_COLS_DEF   = 7;
   localparam int GLYPH_ROWS_DEF   = 8;

   localparam int FONT_IDX_W  = 12;
   localparam int FONT_ADDR_W = 24;

   localparam logic [7:0] CMD_CASET  = 8'h2A;
   localparam logic [7:0] CMD_PASET  = 8'h2B;
   localparam logic [7:0] CMD_RAMWR  = 8'h2C;
   localparam logic [7:0] CMD_MADCTL = 8'h36;

   localparam logic [7:0] MADCTL_ROT0 = 8'h48;
   localparam logic [7:0] MADCTL_ROT1 = 8'h28;
   localparam logic [7:0] MADCTL_ROT2 = 8'h88;
   localparam logic [7:0] MADCTL_ROT3 = 8'hE8;

   typedef enum logic [2:0] {
      OP_FILL = 3'd0,
      OP_CHAR = 3'd1,
      OP_ROT  = 3'd2,
      OP_FONT = 3'd3,
      OP_ADV  = 3'd4
   } op_type;

   typedef enum logic [6:0] {
      PH_IDLE     = 7'b0000001,
      PH_HDR_FILL = 7'b0000010,
      PH_HDR_CHAR = 7'b0000100,
      PH_PIX_FILL = 7'b0001000,
      PH_PIX_CHAR = 7'b0010000,
      PH_ROT_CMD  = 7'b0100000,
      PH_ROT_DATA = 7'b1000000
   } phase_type;

   typedef enum logic [3:0] {
      HS_CASET = 4'd0,
      HS_XS_HI = 4'd1,
      HS_XS_LO = 4'd2,
      HS_XE_HI = 4'd3,
      HS_XE_LO = 4'd4,
      HS_PASET = 4'd5,
      HS_YS_HI = 4'd6,
      HS_YS_LO = 4'd7,
      HS_YE_HI = 4'd8,
      HS_YE_LO = 4'd9,
      HS_RAMWR = 4'd10
   } hdr_step_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] width;
      logic [15:0] height;
      logic [15:0] fore_colour;
      logic [15:0] back_colour;
      logic [7:0]  char_code;
      logic [7:0]  rotation;
      logic [10:0] font_index;
      logic [7:0]  font_row;
   } req_item_type;

   typedef struct packed {
      logic [7:0] spi_byte;
      logic       is_data;
      logic       select_release;
      logic       draw_done;
   } rsp_item_type;

   typedef struct packed {
      logic                  en;
      logic [FONT_IDX_W-1:0] index;
      logic [7:0]            data;
   } font_wr_type;

   function automatic logic [7:0] rot_code(input logic [1:0] sel);
      logic [7:0] code;
      case (sel)
         2'd0:    code = MADCTL_ROT0;
         2'd1:    code = MADCTL_ROT1;
         2'd2:    code = MADCTL_ROT2;
         default: code = MADCTL_ROT3;
      endcase
      return code;
   endfunction

endpackage

// ===== src/tftwg_font_store.sv =====
`timescale 1ns / 1ps

module tftwg_font_store #(
   parameter int FONT_ENTRIES = tftwg_pkg::FONT_ENTRIES_DEF
) (
   input  logic                                clock,
   input  tftwg_pkg::font_wr_type              wr,
   input  logic [tftwg_pkg::FONT_ADDR_W-1:0]   rd_addr,
   output logic [7:0]                          rd_bits
);
   import tftwg_pkg::*;

   localparam int AW = $clog2(FONT_ENTRIES);

   logic [7:0] mem [FONT_ENTRIES];
   logic [7:0] rd_data_ff;
   logic       rd_ok_ff;
   logic       rd_ok;
   logic       fwd;

   assign rd_ok = rd_addr < FONT_ADDR_W'(FONT_ENTRIES);
   assign fwd   = wr.en && (FONT_ADDR_W'(wr.index) == rd_addr);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.index[AW-1:0]] <= wr.data;
      end
   end

   // write-first: a load seen in the same cycle as its read wins
   always_ff @(posedge clock) begin
      rd_ok_ff <= rd_ok;
      if (fwd) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= mem[rd_addr[AW-1:0]];
      end
   end

   assign rd_bits = rd_ok_ff ? rd_data_ff : 8'h00;

endmodule

// ===== src/tftwg_engine.sv =====
`timescale 1ns / 1ps

module tftwg_engine #(
   parameter int FONT_ENTRIES = tftwg_pkg::FONT_ENTRIES_DEF,
   parameter int GLYPH_COLS   = tftwg_pkg::GLYPH_COLS_DEF,
   parameter int GLYPH_ROWS   = tftwg_pkg::GLYPH_ROWS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               fire,
   input  tftwg_pkg::req_item_type            item,
   input  logic [7:0]                         font_bits,
   output logic                               has_result,
   output tftwg_pkg::rsp_item_type            result,
   output tftwg_pkg::font_wr_type             font_wr,
   output logic [tftwg_pkg::FONT_ADDR_W-1:0]  font_rd_addr
);
   import tftwg_pkg::*;

   phase_type    phase_ff, phase_in;
   hdr_step_type step_ff, step_in;
   logic [15:0]  xs_ff, xs_in, xe_ff, xe_in, ys_ff, ys_in, ye_ff, ye_in;
   logic [15:0]  col_ff, col_in, row_ff, row_in;
   logic         low_next_ff, low_next_in;
   logic [31:0]  held_ff, held_in;
   logic [7:0]   glyph_ff, glyph_in;
   logic         loaded_ff, loaded_in;

   logic [15:0]  last_col, last_row, colour, shift;
   logic         pix_on, last_pix;
   logic [7:0]   glyph_map;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         step_ff     <= HS_CASET;
         xs_ff       <= '0;
         xe_ff       <= '0;
         ys_ff       <= '0;
         ye_ff       <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         low_next_ff <= 1'b0;
         held_ff     <= '0;
         glyph_ff    <= '0;
         loaded_ff   <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         step_ff     <= step_in;
         xs_ff       <= xs_in;
         xe_ff       <= xe_in;
         ys_ff       <= ys_in;
         ye_ff       <= ye_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         low_next_ff <= low_next_in;
         held_ff     <= held_in;
         glyph_ff    <= glyph_in;
         loaded_ff   <= loaded_in;
      end
   end

   assign last_col = xe_ff - xs_ff;
   assign last_row = ye_ff - ys_ff;
   assign last_pix = (col_ff == last_col) && (row_ff == last_row);
   assign shift    = 16'(GLYPH_COLS - 1) - col_ff;
   assign pix_on   = (shift < 16'd8) && font_bits[shift[2:0]];

   always_comb begin
      if (phase_ff == PH_PIX_FILL) begin
         colour = held_ff[31:16];
      end else begin
         colour = pix_on ? held_ff[31:16] : held_ff[15:0];
      end
   end

   always_comb begin
      if (item.char_code inside {[8'd32:8'd63]}) begin
         glyph_map = item.char_code + 8'd64;
      end else if (item.char_code >= 8'd96) begin
         glyph_map = item.char_code - 8'd32;
      end else begin
         glyph_map = item.char_code;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      step_in     = step_ff;
      xs_in       = xs_ff;
      xe_in       = xe_ff;
      ys_in       = ys_ff;
      ye_in       = ye_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      low_next_in = low_next_ff;
      held_in     = held_ff;
      glyph_in    = glyph_ff;
      loaded_in   = loaded_ff;
      has_result  = 1'b0;
      result      = '0;
      font_wr     = '0;
      if (fire) begin
         case (item.op)
            OP_FILL: begin
               if (phase_ff == PH_IDLE && item.width != '0 && item.height != '0) begin
                  xs_in    = item.pos_x;
                  xe_in    = item.pos_x + item.width - 16'd1;
                  ys_in    = item.pos_y;
                  ye_in    = item.pos_y + item.height - 16'd1;
                  held_in  = {item.fore_colour, 16'h0000};
                  step_in  = HS_CASET;
                  phase_in = PH_HDR_FILL;
               end
            end
            OP_CHAR: begin
               if (phase_ff == PH_IDLE && loaded_ff) begin
                  glyph_in = glyph_map;
                  xs_in    = item.pos_x;
                  xe_in    = item.pos_x + 16'(GLYPH_COLS - 1);
                  ys_in    = item.pos_y;
                  ye_in    = item.pos_y + 16'(GLYPH_ROWS - 1);
                  held_in  = {item.fore_colour, item.back_colour};
                  step_in  = HS_CASET;
                  phase_in = PH_HDR_CHAR;
               end
            end
            OP_ROT: begin
               if (phase_ff == PH_IDLE) begin
                  held_in  = {24'h000000, rot_code(item.rotation[1:0])};
                  phase_in = PH_ROT_CMD;
               end
            end
            OP_FONT: begin
               if (32'(item.font_index) < FONT_ENTRIES) begin
                  font_wr.en    = 1'b1;
                  font_wr.index = FONT_IDX_W'(item.font_index);
                  font_wr.data  = item.font_row;
                  loaded_in     = 1'b1;
               end
            end
            OP_ADV: begin
               case (phase_ff)
                  PH_HDR_FILL, PH_HDR_CHAR: begin
                     has_result     = 1'b1;
                     result.is_data = 1'b1;
                     step_in        = hdr_step_type'(step_ff + 4'd1);
                     case (step_ff)
                        HS_CASET: begin
                           result.spi_byte       = CMD_CASET;
                           result.is_data        = 1'b0;
                           result.select_release = 1'b1;
                        end
                        HS_XS_HI: result.spi_byte = xs_ff[15:8];
                        HS_XS_LO: result.spi_byte = xs_ff[7:0];
                        HS_XE_HI: result.spi_byte = xe_ff[15:8];
                        HS_XE_LO: begin
                           result.spi_byte       = xe_ff[7:0];
                           result.select_release = 1'b1;
                        end
                        HS_PASET: begin
                           result.spi_byte       = CMD_PASET;
                           result.is_data        = 1'b0;
                           result.select_release = 1'b1;
                        end
                        HS_YS_HI: result.spi_byte = ys_ff[15:8];
                        HS_YS_LO: result.spi_byte = ys_ff[7:0];
                        HS_YE_HI: result.spi_byte = ye_ff[15:8];
                        HS_YE_LO: begin
                           result.spi_byte       = ye_ff[7:0];
                           result.select_release = 1'b1;
                        end
                        HS_RAMWR: begin
                           result.spi_byte = CMD_RAMWR;
                           result.is_data  = 1'b0;
                           step_in         = HS_CASET;
                           col_in          = '0;
                           row_in          = '0;
                           low_next_in     = 1'b0;
                           phase_in        = (phase_ff == PH_HDR_FILL) ? PH_PIX_FILL
                                                                       : PH_PIX_CHAR;
                        end
                        default: begin
                           result.spi_byte = ye_ff[7:0];
                           step_in         = HS_CASET;
                           col_in          = '0;
                           row_in          = '0;
                           low_next_in     = 1'b0;
                           phase_in        = (phase_ff == PH_HDR_FILL) ? PH_PIX_FILL
                                                                       : PH_PIX_CHAR;
                        end
                     endcase
                  end
                  PH_PIX_FILL, PH_PIX_CHAR: begin
                     has_result     = 1'b1;
                     result.is_data = 1'b1;
                     if (!low_next_ff) begin
                        result.spi_byte = colour[15:8];
                        low_next_in     = 1'b1;
                     end else begin
                        result.spi_byte = colour[7:0];
                        low_next_in     = 1'b0;
                        if (last_pix) begin
                           result.select_release = 1'b1;
                           result.draw_done      = 1'b1;
                           phase_in              = PH_IDLE;
                           col_in                = '0;
                           row_in                = '0;
                        end else if (col_ff == last_col) begin
                           col_in = '0;
                           row_in = row_ff + 16'd1;
                        end else begin
                           col_in = col_ff + 16'd1;
                        end
                     end
                  end
                  PH_ROT_CMD: begin
                     has_result            = 1'b1;
                     result.spi_byte       = CMD_MADCTL;
                     result.select_release = 1'b1;
                     phase_in              = PH_ROT_DATA;
                  end
                  PH_ROT_DATA: begin
                     has_result            = 1'b1;
                     result.spi_byte       = held_ff[7:0];
                     result.is_data        = 1'b1;
                     result.select_release = 1'b1;
                     result.draw_done      = 1'b1;
                     phase_in              = PH_IDLE;
                  end
                  default: begin
                     has_result = 1'b0;
                  end
               endcase
            end
            default: begin
               has_result = 1'b0;
            end
         endcase
      end
   end

   // font row for the state of the next cycle, so the read data lines up
   always_comb begin
      if (reset) begin
         font_rd_addr = '0;
      end else begin
         font_rd_addr = FONT_ADDR_W'(glyph_in) * FONT_ADDR_W'(GLYPH_ROWS)
                        + FONT_ADDR_W'(row_in);
      end
   end

endmodule

// ===== src/tft_window_fill_and_glyph_sequencer.sv =====
`timescale 1ns / 1ps

// channel   ports        beat
// -------   ----------   ----------------------------------------------
// request   req_*        one command: fill, char, rotation, font, advance
// response  rsp_*        one spi byte with d/c, cs release and done flags
//
// one request per cycle while no response stalls; an advance beat passes the
// input register, then the result register, before its response is offered
// the font row for the current pixel row is read ahead from the font ram
// reset clears the sequencer state and the font loaded flag, not the font ram
// a stalled response holds the result register; the input register still
// takes a beat while it is empty

module tft_window_fill_and_glyph_sequencer #(
   parameter int FONT_ENTRIES = tftwg_pkg::FONT_ENTRIES_DEF,
   parameter int GLYPH_COLS   = tftwg_pkg::GLYPH_COLS_DEF,
   parameter int GLYPH_ROWS   = tftwg_pkg::GLYPH_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [15:0] req_pos_x,
   input  logic [15:0] req_pos_y,
   input  logic [15:0] req_width,
   input  logic [15:0] req_height,
   input  logic [15:0] req_fore_colour,
   input  logic [15:0] req_back_colour,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_rotation,
   input  logic [10:0] req_font_index,
   input  logic [7:0]  req_font_row,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_spi_byte,
   output logic        rsp_is_data,
   output logic        rsp_select_release,
   output logic        rsp_draw_done
);
   import tftwg_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   req_item_type           in_item_ff;
   logic                   out_valid_ff, out_valid_in;
   rsp_item_type           out_item_ff;
   logic                   fire;
   logic                   has_result;
   rsp_item_type           result;
   font_wr_type            font_wr;
   logic [FONT_ADDR_W-1:0] font_rd_addr;
   logic [7:0]             font_bits;

   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = has_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= '{op: req_op, pos_x: req_pos_x, pos_y: req_pos_y,
                         width: req_width, height: req_height,
                         fore_colour: req_fore_colour, back_colour: req_back_colour,
                         char_code: req_char_code, rotation: req_rotation,
                         font_index: req_font_index, font_row: req_font_row};
      end
      if (fire && has_result) begin
         out_item_ff <= result;
      end
   end

   tftwg_engine #(
      .FONT_ENTRIES(FONT_ENTRIES),
      .GLYPH_COLS  (GLYPH_COLS),
      .GLYPH_ROWS  (GLYPH_ROWS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .item        (in_item_ff),
      .font_bits   (font_bits),
      .has_result  (has_result),
      .result      (result),
      .font_wr     (font_wr),
      .font_rd_addr(font_rd_addr)
   );

   tftwg_font_store #(
      .FONT_ENTRIES(FONT_ENTRIES)
   ) u_font (
      .clock  (clock),
      .wr     (font_wr),
      .rd_addr(font_rd_addr),
      .rd_bits(font_bits)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_spi_byte       = out_item_ff.spi_byte;
   assign rsp_is_data        = out_item_ff.is_data;
   assign rsp_select_release = out_item_ff.select_release;
   assign rsp_draw_done      = out_item_ff.draw_done;

endmodule

// ===== src/tftwg_checker.sv =====
`timescale 1ns / 1ps

module tftwg_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_spi_byte,
   input logic       rsp_is_data,
   input logic       rsp_select_release,
   input logic       rsp_draw_done
);
   import tftwg_pkg::*;

   // response beat held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid after reset");

   // a command beat is one of the four controller commands
   a_cmd_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_data |->
         rsp_spi_byte == CMD_CASET || rsp_spi_byte == CMD_PASET ||
         rsp_spi_byte == CMD_RAMWR || rsp_spi_byte == CMD_MADCTL)
      else $error("unknown command byte");

   // the last beat of a draw is data and releases chip select
   a_done_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_draw_done |-> rsp_is_data && rsp_select_release)
      else $error("draw end without data and release");

   // chip select stays low from memory write into the pixels
   a_ramwr_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_data && rsp_spi_byte == CMD_RAMWR |->
         !rsp_select_release && !rsp_draw_done)
      else $error("release after memory write command");

endmodule

bind tft_window_fill_and_glyph_sequencer tftwg_checker u_checker (.*);

// ===== tb/tft_stream_checker.sv =====
`timescale 1ns / 1ps

module tft_stream_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [15:0] req_pos_x,
   input  logic [15:0] req_pos_y,
   input  logic [15:0] req_width,
   input  logic [15:0] req_height,
   input  logic [15:0] req_fore_colour,
   input  logic [15:0] req_back_colour,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_rotation,
   input  logic [10:0] req_font_index,
   input  logic [7:0]  req_font_row,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_spi_byte,
   input  logic        rsp_is_data,
   input  logic        rsp_select_release,
   input  logic        rsp_draw_done,
   output int          fail_count,
   output int          pending_count
);

   import tftwg_pkg::*;

   localparam int FONT_DEPTH = FONT_ENTRIES_DEF;
   localparam int GLYPH_W    = GLYPH_COLS_DEF;
   localparam int GLYPH_H    = GLYPH_ROWS_DEF;

   phase_type    seq_phase;
   hdr_step_type hdr_step;
   logic [15:0]  x_lo, x_hi, y_lo, y_hi;
   logic [15:0]  col_pos, row_pos;
   logic         low_half;
   logic [31:0]  colour_pair;
   logic [7:0]   glyph_sel;
   logic [7:0]   font_mem [FONT_DEPTH];
   logic         font_ready;
   rsp_item_type spi_expect [$];

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      if (fail_count < 200)
         $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   task automatic push_byte(input logic [7:0] b, input logic dat, input logic rel,
                            input logic done);
      rsp_item_type r;
      r.spi_byte       = b;
      r.is_data        = dat;
      r.select_release = rel;
      r.draw_done      = done;
      spi_expect.push_back(r);
   endtask

   task automatic clear_sequencer();
      seq_phase   = PH_IDLE;
      hdr_step    = HS_CASET;
      x_lo        = '0;
      x_hi        = '0;
      y_lo        = '0;
      y_hi        = '0;
      col_pos     = '0;
      row_pos     = '0;
      low_half    = 1'b0;
      colour_pair = '0;
      glyph_sel   = '0;
      font_ready  = 1'b0;
      spi_expect.delete();
   endtask

   task automatic window_byte();
      hdr_step_type s;
      s = hdr_step;
      case (s)
         HS_CASET: push_byte(CMD_CASET, 1'b0, 1'b1, 1'b0);
         HS_XS_HI: push_byte(x_lo[15:8], 1'b1, 1'b0, 1'b0);
         HS_XS_LO: push_byte(x_lo[7:0], 1'b1, 1'b0, 1'b0);
         HS_XE_HI: push_byte(x_hi[15:8], 1'b1, 1'b0, 1'b0);
         HS_XE_LO: push_byte(x_hi[7:0], 1'b1, 1'b1, 1'b0);
         HS_PASET: push_byte(CMD_PASET, 1'b0, 1'b1, 1'b0);
         HS_YS_HI: push_byte(y_lo[15:8], 1'b1, 1'b0, 1'b0);
         HS_YS_LO: push_byte(y_lo[7:0], 1'b1, 1'b0, 1'b0);
         HS_YE_HI: push_byte(y_hi[15:8], 1'b1, 1'b0, 1'b0);
         HS_YE_LO: push_byte(y_hi[7:0], 1'b1, 1'b1, 1'b0);
         default:  push_byte(CMD_RAMWR, 1'b0, 1'b0, 1'b0);
      endcase
      if (s == HS_RAMWR) begin
         hdr_step  = HS_CASET;
         col_pos   = '0;
         row_pos   = '0;
         low_half  = 1'b0;
         seq_phase = (seq_phase == PH_HDR_FILL) ? PH_PIX_FILL : PH_PIX_CHAR;
      end else begin
         hdr_step = hdr_step_type'(s + 4'd1);
      end
   endtask

   task automatic pixel_byte();
      logic [15:0] last_c, last_r, colour;
      logic [7:0]  bits;
      int          addr, sh;
      logic        lit;
      last_c = x_hi - x_lo;
      last_r = y_hi - y_lo;
      if (seq_phase == PH_PIX_FILL) begin
         colour = colour_pair[31:16];
      end else begin
         addr   = int'(glyph_sel) * GLYPH_H + int'(row_pos);
         bits   = (addr < FONT_DEPTH) ? font_mem[addr] : 8'h00;
         sh     = GLYPH_W - 1 - int'(col_pos);
         lit    = (sh >= 0 && sh < 8) ? bits[sh] : 1'b0;
         colour = lit ? colour_pair[31:16] : colour_pair[15:0];
      end
      if (!low_half) begin
         push_byte(colour[15:8], 1'b1, 1'b0, 1'b0);
         low_half = 1'b1;
      end else begin
         low_half = 1'b0;
         if (col_pos == last_c && row_pos == last_r) begin
            push_byte(colour[7:0], 1'b1, 1'b1, 1'b1);
            seq_phase = PH_IDLE;
            col_pos   = '0;
            row_pos   = '0;
         end else begin
            push_byte(colour[7:0], 1'b1, 1'b0, 1'b0);
            if (col_pos == last_c) begin
               col_pos = '0;
               row_pos = row_pos + 16'd1;
            end else begin
               col_pos = col_pos + 16'd1;
            end
         end
      end
   endtask

   task automatic sequencer_step(input req_item_type it);
      logic [7:0] code;
      case (it.op)
         OP_FILL: begin
            if (seq_phase == PH_IDLE && it.width != 0 && it.height != 0) begin
               x_lo        = it.pos_x;
               x_hi        = it.pos_x + it.width - 16'd1;
               y_lo        = it.pos_y;
               y_hi        = it.pos_y + it.height - 16'd1;
               colour_pair = {it.fore_colour, 16'h0000};
               hdr_step    = HS_CASET;
               seq_phase   = PH_HDR_FILL;
            end
         end
         OP_CHAR: begin
            if (seq_phase == PH_IDLE && font_ready) begin
               code = it.char_code;
               if (code >= 8'd32 && code <= 8'd63) code = code + 8'd64;
               else if (code >= 8'd96) code = code - 8'd32;
               glyph_sel   = code;
               x_lo        = it.pos_x;
               x_hi        = it.pos_x + 16'(GLYPH_W - 1);
               y_lo        = it.pos_y;
               y_hi        = it.pos_y + 16'(GLYPH_H - 1);
               colour_pair = {it.fore_colour, it.back_colour};
               hdr_step    = HS_CASET;
               seq_phase   = PH_HDR_CHAR;
            end
         end
         OP_ROT: begin
            if (seq_phase == PH_IDLE) begin
               case (it.rotation[1:0])
                  2'd0:    colour_pair = {24'h0, MADCTL_ROT0};
                  2'd1:    colour_pair = {24'h0, MADCTL_ROT1};
                  2'd2:    colour_pair = {24'h0, MADCTL_ROT2};
                  default: colour_pair = {24'h0, MADCTL_ROT3};
               endcase
               seq_phase = PH_ROT_CMD;
            end
         end
         OP_FONT: begin
            if (int'(it.font_index) < FONT_DEPTH) begin
               font_mem[it.font_index] = it.font_row;
               font_ready              = 1'b1;
            end
         end
         OP_ADV: begin
            case (seq_phase)
               PH_HDR_FILL, PH_HDR_CHAR: window_byte();
               PH_PIX_FILL, PH_PIX_CHAR: pixel_byte();
               PH_ROT_CMD: begin
                  push_byte(CMD_MADCTL, 1'b0, 1'b1, 1'b0);
                  seq_phase = PH_ROT_DATA;
               end
               PH_ROT_DATA: begin
                  push_byte(colour_pair[7:0], 1'b1, 1'b1, 1'b1);
                  seq_phase = PH_IDLE;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         clear_sequencer();
         fail_count = 0;
      end else begin
         if (req_valid && req_ready)
            sequencer_step(req_item_type'({req_op, req_pos_x, req_pos_y, req_width,
                                           req_height, req_fore_colour, req_back_colour,
                                           req_char_code, req_rotation, req_font_index,
                                           req_font_row}));
         if (rsp_valid && rsp_ready) begin
            if (spi_expect.size() == 0) begin
               report_mismatch("unexpected beat", rsp_spi_byte, 8'h00);
            end else begin
               want = spi_expect.pop_front();
               if (rsp_spi_byte !== want.spi_byte)
                  report_mismatch("spi_byte", rsp_spi_byte, want.spi_byte);
               if (rsp_is_data !== want.is_data)
                  report_mismatch("is_data", 8'(rsp_is_data), 8'(want.is_data));
               if (rsp_select_release !== want.select_release)
                  report_mismatch("select_release", 8'(rsp_select_release),
                                  8'(want.select_release));
               if (rsp_draw_done !== want.draw_done)
                  report_mismatch("draw_done", 8'(rsp_draw_done), 8'(want.draw_done));
            end
         end
      end
      pending_count = spi_expect.size();
   end

endmodule

// ===== tb/tb_tft_window_fill_and_glyph_sequencer.sv =====
`timescale 1ns / 1ps

module tb_tft_window_fill_and_glyph_sequencer;

   import tftwg_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int BULK_ITEMS  = 600;
   localparam int CALM_AFTER  = 520;
   localparam int HOLD_CYCLES = 300;
   localparam int GLYPH_BEATS = 11 + 2 * GLYPH_COLS_DEF * GLYPH_ROWS_DEF;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_op = '0;
   logic [15:0] req_pos_x = '0;
   logic [15:0] req_pos_y = '0;
   logic [15:0] req_width = '0;
   logic [15:0] req_height = '0;
   logic [15:0] req_fore_colour = '0;
   logic [15:0] req_back_colour = '0;
   logic [7:0]  req_char_code = '0;
   logic [7:0]  req_rotation = '0;
   logic [10:0] req_font_index = '0;
   logic [7:0]  req_font_row = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_spi_byte;
   logic        rsp_is_data;
   logic        rsp_select_release;
   logic        rsp_draw_done;

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   int bulk_count = 0;
   bit calm = 1'b0;
   bit hold_request = 1'b0;

   // character codes in use and the glyphs they land on
   int char_set [7] = '{0, 31, 32, 63, 95, 96, 255};
   int glyph_set [7] = '{0, 31, 96, 127, 95, 64, 223};
   int rot_sel [5] = '{0, 1, 2, 3, 255};

   tft_window_fill_and_glyph_sequencer u_top (.*);

   tft_stream_checker u_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic req_item_type any_item(input logic [2:0] op);
      req_item_type it;
      it.op          = op;
      it.pos_x       = 16'($urandom);
      it.pos_y       = 16'($urandom);
      it.width       = 16'($urandom);
      it.height      = 16'($urandom);
      it.fore_colour = 16'($urandom);
      it.back_colour = 16'($urandom);
      it.char_code   = 8'(char_set[$urandom_range(0, 6)]);
      it.rotation    = 8'($urandom);
      it.font_index  = 11'($urandom);
      it.font_row    = 8'($urandom);
      return it;
   endfunction

   function automatic int draw_length(input req_item_type it);
      case (it.op)
         OP_FILL: return (it.width == 0 || it.height == 0) ? 0 :
                         11 + 2 * int'(it.width) * int'(it.height);
         OP_CHAR: return GLYPH_BEATS;
         OP_ROT:  return 2;
         default: return 0;
      endcase
   endfunction

   task automatic send_beat(input req_item_type it);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_op          <= it.op;
      req_pos_x       <= it.pos_x;
      req_pos_y       <= it.pos_y;
      req_width       <= it.width;
      req_height      <= it.height;
      req_fore_colour <= it.fore_colour;
      req_back_colour <= it.back_colour;
      req_char_code   <= it.char_code;
      req_rotation    <= it.rotation;
      req_font_index  <= it.font_index;
      req_font_row    <= it.font_row;
      req_valid       <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // draw command, its advance beats, and optional stray beats mixed in
   task automatic run_draw(input req_item_type cmd, input int beats, input bit noisy);
      send_beat(cmd);
      bulk_count++;
      for (int i = 0; i < beats; i++) begin
         if (noisy && $urandom_range(0, 15) == 0)
            send_beat(any_item(3'($urandom_range(0, 3))));
         send_beat(any_item(OP_ADV));
         bulk_count++;
      end
   endtask

   initial begin
      bit hold_done;
      int n;
      hold_done = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 11);
            rsp_ready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      req_item_type it;
      int           pick, beats;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // char before any font byte, idle advance, unused ops, empty rectangles
      send_beat(any_item(OP_CHAR));
      send_beat(any_item(OP_ADV));
      for (int k = 5; k < 8; k++) send_beat(any_item(3'(k)));
      it = any_item(OP_FILL);
      it.width  = 16'hFFFF;
      it.height = 16'h0000;
      send_beat(it);
      it = any_item(OP_FILL);
      it.width  = 16'h0000;
      it.height = 16'hFFFF;
      send_beat(it);

      // glyph rows for every character code the stimulus uses
      foreach (glyph_set[g]) begin
         for (int r = 0; r < GLYPH_ROWS_DEF; r++) begin
            it = any_item(OP_FONT);
            it.font_index = 11'(glyph_set[g] * GLYPH_ROWS_DEF + r);
            send_beat(it);
         end
      end

      it = any_item(OP_FILL);
      it.pos_x       = 16'h0000;
      it.pos_y       = 16'h0000;
      it.width       = 16'd1;
      it.height      = 16'd1;
      it.fore_colour = 16'hFFFF;
      run_draw(it, draw_length(it), 1'b0);
      // window ends wrap past 16 bits
      it = any_item(OP_FILL);
      it.pos_x       = 16'hFFFF;
      it.pos_y       = 16'hFFFE;
      it.width       = 16'd3;
      it.height      = 16'd4;
      it.fore_colour = 16'h0000;
      run_draw(it, draw_length(it), 1'b0);
      it = any_item(OP_FILL);
      it.width  = 16'd8;
      it.height = 16'd2;
      run_draw(it, draw_length(it), 1'b0);

      foreach (rot_sel[r]) begin
         it = any_item(OP_ROT);
         it.rotation = 8'(rot_sel[r]);
         send_beat(it);
         if (r == 4) begin
            it = any_item(OP_FILL);
            it.width  = 16'd2;
            it.height = 16'd2;
            send_beat(it);
            send_beat(any_item(OP_FONT));
         end
         send_beat(any_item(OP_ADV));
         send_beat(any_item(OP_ADV));
      end

      it = any_item(OP_CHAR);
      it.char_code = 8'(char_set[0]);
      it.pos_x     = 16'hFFFC;
      it.pos_y     = 16'hFFFC;
      run_draw(it, GLYPH_BEATS, 1'b0);
      it = any_item(OP_CHAR);
      it.char_code = 8'(char_set[6]);
      run_draw(it, GLYPH_BEATS, 1'b1);
      send_beat(any_item(OP_ADV));

      // long receiver hold-off while a glyph streams
      bulk_count   = 0;
      hold_request = 1'b1;
      run_draw(any_item(OP_CHAR), GLYPH_BEATS, 1'b0);

      while (bulk_count < BULK_ITEMS) begin
         if (bulk_count >= CALM_AFTER) calm = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 82) begin
            if (pick < 45) begin
               it = any_item(OP_FILL);
               it.width  = 16'($urandom_range(1, (pick < 5) ? 24 : 6));
               it.height = 16'($urandom_range(1, 4));
            end else if (pick < 60) begin
               it = any_item(OP_CHAR);
            end else if (pick < 75) begin
               it = any_item(OP_ROT);
            end else begin
               it = any_item(OP_FILL);
               if ($urandom_range(0, 1) == 0) it.width = 16'h0000;
               else it.height = 16'h0000;
            end
            beats = draw_length(it);
            // broken sequence: stop short and let later commands meet a busy block
            if ($urandom_range(0, 19) == 0) beats = $urandom_range(0, beats);
            run_draw(it, beats, 1'b1);
         end else if (pick < 90) begin
            send_beat(any_item(OP_FONT));
            bulk_count++;
         end else if (pick < 95) begin
            send_beat(any_item(OP_ADV));
         end else begin
            send_beat(any_item(3'($urandom_range(5, 7))));
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/tftwg_pkg.sv
src/tftwg_font_store.sv
src/tftwg_engine.sv
src/tft_window_fill_and_glyph_sequencer.sv
src/tftwg_checker.sv
tb/tft_stream_checker.sv
tb/tb_tft_window_fill_and_glyph_sequencer.sv
